// ===== rtl/core/doubly_linked_list_cursor_engine_macros.svh =====
// Assertion macros for the linked list cursor engine
`ifndef DOUBLY_LINKED_LIST_CURSOR_ENGINE_MACROS_SVH
`define DOUBLY_LINKED_LIST_CURSOR_ENGINE_MACROS_SVH

// Check that a condition implies another in the same cycle
`define DLLCE_ASSERT_SAME(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("dllce assertion failed");

// Check that a condition implies another in the next cycle
`define DLLCE_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("dllce assertion failed");

`endif

// ===== rtl/core/dllce_pkg.sv =====
// Shared constants and opcodes of the linked list cursor engine
`default_nettype none
package dllce_pkg;
    localparam int OPCODE_W = 5;
    localparam int WORD_W   = 32;

    localparam logic [OPCODE_W-1:0] OP_CLEAR      = 5'd0;
    localparam logic [OPCODE_W-1:0] OP_INS_FIRST  = 5'd1;
    localparam logic [OPCODE_W-1:0] OP_INS_LAST   = 5'd2;
    localparam logic [OPCODE_W-1:0] OP_CUR_FIRST  = 5'd3;
    localparam logic [OPCODE_W-1:0] OP_CUR_LAST   = 5'd4;
    localparam logic [OPCODE_W-1:0] OP_RD_FIRST   = 5'd5;
    localparam logic [OPCODE_W-1:0] OP_RD_LAST    = 5'd6;
    localparam logic [OPCODE_W-1:0] OP_DEL_FIRST  = 5'd7;
    localparam logic [OPCODE_W-1:0] OP_DEL_LAST   = 5'd8;
    localparam logic [OPCODE_W-1:0] OP_DEL_AFTER  = 5'd9;
    localparam logic [OPCODE_W-1:0] OP_DEL_BEFORE = 5'd10;
    localparam logic [OPCODE_W-1:0] OP_INS_AFTER  = 5'd11;
    localparam logic [OPCODE_W-1:0] OP_INS_BEFORE = 5'd12;
    localparam logic [OPCODE_W-1:0] OP_RD_ACTIVE  = 5'd13;
    localparam logic [OPCODE_W-1:0] OP_WR_ACTIVE  = 5'd14;
    localparam logic [OPCODE_W-1:0] OP_NEXT       = 5'd15;
    localparam logic [OPCODE_W-1:0] OP_PREV       = 5'd16;
endpackage
`default_nettype wire

// ===== rtl/core/dllce_req_if.sv =====
// Request channel: opcode and value words into the engine
`default_nettype none
interface dllce_req_if;
    import dllce_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [OPCODE_W-1:0]      opcode;
    logic signed [WORD_W-1:0] value_in;

    modport source (output valid, output opcode, output value_in, input ready);
    modport sink (input valid, input opcode, input value_in, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dllce_rsp_if.sv =====
// Response channel: one status word per request
`default_nettype none
interface dllce_rsp_if #(
    parameter int CNT_W = 7
);
    import dllce_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] read_value;
    logic                     read_valid;
    logic                     error;
    logic                     cursor_active;
    logic [CNT_W-1:0]         element_count;

    modport source (output valid, output read_value, output read_valid, output error,
                    output cursor_active, output element_count, input ready);
    modport sink (input valid, input read_value, input read_valid, input error,
                  input cursor_active, input element_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dllce_ram.sv =====
// Generic single write, single read RAM with registered read data
`default_nettype none
module dllce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/doubly_linked_list_cursor_engine.sv =====
// Top level of the doubly linked list cursor engine
//
// Usage: a request word (opcode, value_in) enters on req when valid and
// ready are both high; one response word leaves on rsp for every request.
// Requests are handled one at a time by a sequencer around four RAMs
// (node values, next links, previous links, free stack), each with
// registered read data.
// Every request ends in S_DONE, which fills the output register. Clear,
// cursor moves to first or last, write active, unused opcodes, reads with
// no target, inserts into a full pool and requests with no cursor go
// straight there; reads pass through S_RDVAL, next and previous through
// S_MOVE, delete first or last on a non-empty list through S_UNLINK,
// inserts through S_ALLOC and S_LINK, and delete after or before through
// S_NBR and, if that neighbor exists, S_UNLINK. Each RAM read is
// registered, and an insert spends S_LINK pointing the neighbors at the
// new node. req.ready rises in the same cycle as the response turns valid.
// The sequencer holds in its final state while a stalled response
// occupies the output register, and req.ready stays low meanwhile.
// Reset empties the list at once: the free stack reads its initial node
// order through a low-water mark, so no clearing pass is needed; clear does the same.
`default_nettype none
`include "doubly_linked_list_cursor_engine_macros.svh"
module doubly_linked_list_cursor_engine #(
    parameter int POOL_ENTRIES = 64,
    parameter int VALUE_WIDTH  = 32
) (
    input wire logic     clk,
    input wire logic     rst_n,
    dllce_req_if.sink    req,
    dllce_rsp_if.source  rsp
);
    import dllce_pkg::*;

    localparam int AW = $clog2(POOL_ENTRIES);
    localparam int LW = $clog2(POOL_ENTRIES + 1);
    localparam logic [LW-1:0] NIL  = LW'(POOL_ENTRIES);
    localparam logic [63:0] VMASK = (VALUE_WIDTH >= 64) ? {64{1'b1}} :
                                    ((64'd1 << VALUE_WIDTH) - 64'd1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDVAL  = 4'd1;
    localparam logic [3:0] S_MOVE   = 4'd2;
    localparam logic [3:0] S_NBR    = 4'd3;
    localparam logic [3:0] S_UNLINK = 4'd4;
    localparam logic [3:0] S_ALLOC  = 4'd5;
    localparam logic [3:0] S_LINK   = 4'd6;
    localparam logic [3:0] S_DONE   = 4'd7;

    function automatic logic is_node(input logic [LW-1:0] i);
        return i < NIL;
    endfunction

    // Control registers
    logic [3:0]          state_reg, state_next;
    logic [LW-1:0]       head_reg, head_next;
    logic [LW-1:0]       tail_reg, tail_next;
    logic [LW-1:0]       cur_reg, cur_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [LW-1:0]       fc_reg, fc_next;
    logic [LW-1:0]       low_reg, low_next;
    logic                out_valid_reg, out_valid_next;

    // Payload registers
    logic [OPCODE_W-1:0] op_reg, op_next;
    logic [WORD_W-1:0]   val_reg, val_next;
    logic [LW-1:0]       t_reg, t_next;
    logic [LW-1:0]       n_reg, n_next;
    logic [LW-1:0]       nb_reg, nb_next;
    logic [WORD_W-1:0]   rv_reg, rv_next;
    logic                rvalid_reg, rvalid_next;
    logic                err_reg, err_next;
    logic [WORD_W-1:0]   o_value_reg, o_value_next;
    logic                o_rvalid_reg, o_rvalid_next;
    logic                o_err_reg, o_err_next;
    logic                o_cur_reg, o_cur_next;
    logic [LW-1:0]       o_cnt_reg, o_cnt_next;

    // RAM ports
    logic                   v_we, v_re, n_we, n_re, p_we, p_re, s_we, s_re;
    logic [AW-1:0]          v_waddr, v_raddr, n_waddr, n_raddr;
    logic [AW-1:0]          p_waddr, p_raddr, s_waddr, s_raddr;
    logic [VALUE_WIDTH-1:0] v_wdata, v_rdata;
    logic [LW-1:0]          n_wdata, n_rdata, p_wdata, p_rdata;
    logic [AW-1:0]          s_wdata, s_rdata;

    // Helpers
    logic [LW-1:0]          pop_pos;
    logic [LW-1:0]          new_node;
    logic [LW-1:0]          nbr_link;
    logic [63:0]            ext_value;

    dllce_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(POOL_ENTRIES)) u_value_ram (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .re(v_re), .raddr(v_raddr), .rdata(v_rdata));
    dllce_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_next_ram (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .re(n_re), .raddr(n_raddr), .rdata(n_rdata));
    dllce_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_prev_ram (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .re(p_re), .raddr(p_raddr), .rdata(p_rdata));
    dllce_ram #(.WIDTH(AW), .DEPTH(POOL_ENTRIES)) u_stack_ram (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .re(s_re), .raddr(s_raddr), .rdata(s_rdata));

    // Pop slot; slots below the low-water mark still hold their initial index
    assign pop_pos  = fc_reg - LW'(1);
    assign new_node = (pop_pos >= low_reg) ? LW'(s_rdata) : pop_pos;
    assign nbr_link = (op_reg == OP_DEL_AFTER) ? n_rdata : p_rdata;

    // Sign extend a stored value from its top bit
    always_comb
    begin
        ext_value = 64'(v_rdata);
        if (v_rdata[VALUE_WIDTH-1])
        begin
            ext_value = ext_value | ~VMASK;
        end
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.read_value    = o_value_reg;
    assign rsp.read_valid    = o_rvalid_reg;
    assign rsp.error         = o_err_reg;
    assign rsp.cursor_active = o_cur_reg;
    assign rsp.element_count = o_cnt_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        cur_next = cur_reg;
        len_next = len_reg;
        fc_next = fc_reg;
        low_next = low_reg;
        out_valid_next = out_valid_reg;
        op_next = op_reg;
        val_next = val_reg;
        t_next = t_reg;
        n_next = n_reg;
        nb_next = nb_reg;
        rv_next = rv_reg;
        rvalid_next = rvalid_reg;
        err_next = err_reg;
        o_value_next = o_value_reg;
        o_rvalid_next = o_rvalid_reg;
        o_err_next = o_err_reg;
        o_cur_next = o_cur_reg;
        o_cnt_next = o_cnt_reg;
        v_we = 1'b0; v_re = 1'b0; v_waddr = '0; v_raddr = '0; v_wdata = '0;
        n_we = 1'b0; n_re = 1'b0; n_waddr = '0; n_raddr = '0; n_wdata = '0;
        p_we = 1'b0; p_re = 1'b0; p_waddr = '0; p_raddr = '0; p_wdata = '0;
        s_we = 1'b0; s_re = 1'b0; s_waddr = '0; s_raddr = '0; s_wdata = '0;

        // Drop the output word once taken
        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next = req.opcode;
                    val_next = req.value_in;
                    rv_next = '0;
                    rvalid_next = 1'b0;
                    err_next = 1'b0;
                    state_next = S_DONE;
                    case (req.opcode)
                        OP_CLEAR:
                        begin
                            head_next = NIL;
                            tail_next = NIL;
                            cur_next = NIL;
                            len_next = '0;
                            fc_next = NIL;
                            low_next = NIL;
                        end
                        OP_INS_FIRST, OP_INS_LAST:
                        begin
                            if (fc_reg == '0)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                s_re = 1'b1;
                                s_raddr = pop_pos[AW-1:0];
                                state_next = S_ALLOC;
                            end
                        end
                        OP_CUR_FIRST: cur_next = head_reg;
                        OP_CUR_LAST: cur_next = tail_reg;
                        OP_RD_FIRST, OP_RD_LAST, OP_RD_ACTIVE:
                        begin
                            v_raddr = (req.opcode == OP_RD_FIRST) ? head_reg[AW-1:0] :
                                      (req.opcode == OP_RD_LAST) ? tail_reg[AW-1:0] :
                                      cur_reg[AW-1:0];
                            if ((req.opcode == OP_RD_FIRST && is_node(head_reg)) ||
                                (req.opcode == OP_RD_LAST && is_node(tail_reg)) ||
                                (req.opcode == OP_RD_ACTIVE && is_node(cur_reg)))
                            begin
                                v_re = 1'b1;
                                state_next = S_RDVAL;
                            end
                            else
                            begin
                                err_next = 1'b1;
                            end
                        end
                        OP_DEL_FIRST, OP_DEL_LAST:
                        begin
                            t_next = (req.opcode == OP_DEL_FIRST) ? head_reg : tail_reg;
                            n_raddr = t_next[AW-1:0];
                            p_raddr = t_next[AW-1:0];
                            if (is_node(t_next))
                            begin
                                n_re = 1'b1;
                                p_re = 1'b1;
                                state_next = S_UNLINK;
                            end
                        end
                        OP_DEL_AFTER, OP_DEL_BEFORE:
                        begin
                            if (is_node(cur_reg))
                            begin
                                n_re = (req.opcode == OP_DEL_AFTER);
                                p_re = (req.opcode == OP_DEL_BEFORE);
                                n_raddr = cur_reg[AW-1:0];
                                p_raddr = cur_reg[AW-1:0];
                                state_next = S_NBR;
                            end
                        end
                        OP_INS_AFTER, OP_INS_BEFORE:
                        begin
                            if (is_node(cur_reg))
                            begin
                                if (fc_reg == '0)
                                begin
                                    err_next = 1'b1;
                                end
                                else
                                begin
                                    s_re = 1'b1;
                                    s_raddr = pop_pos[AW-1:0];
                                    n_re = (req.opcode == OP_INS_AFTER);
                                    p_re = (req.opcode == OP_INS_BEFORE);
                                    n_raddr = cur_reg[AW-1:0];
                                    p_raddr = cur_reg[AW-1:0];
                                    state_next = S_ALLOC;
                                end
                            end
                        end
                        OP_WR_ACTIVE:
                        begin
                            if (is_node(cur_reg))
                            begin
                                v_we = 1'b1;
                                v_waddr = cur_reg[AW-1:0];
                                v_wdata = VALUE_WIDTH'($unsigned(req.value_in));
                            end
                        end
                        OP_NEXT, OP_PREV:
                        begin
                            if (is_node(cur_reg))
                            begin
                                n_re = (req.opcode == OP_NEXT);
                                p_re = (req.opcode == OP_PREV);
                                n_raddr = cur_reg[AW-1:0];
                                p_raddr = cur_reg[AW-1:0];
                                state_next = S_MOVE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RDVAL:
            begin
                rv_next = ext_value[WORD_W-1:0];
                rvalid_next = 1'b1;
                state_next = S_DONE;
            end
            S_MOVE:
            begin
                cur_next = (op_reg == OP_NEXT) ? n_rdata : p_rdata;
                state_next = S_DONE;
            end
            S_NBR:
            begin
                // Fetch the links of the neighbor to delete
                t_next = nbr_link;
                n_raddr = nbr_link[AW-1:0];
                p_raddr = nbr_link[AW-1:0];
                if (is_node(nbr_link))
                begin
                    n_re = 1'b1;
                    p_re = 1'b1;
                    state_next = S_UNLINK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_UNLINK:
            begin
                // Bridge the neighbors and push the node back
                if (is_node(p_rdata))
                begin
                    n_we = 1'b1;
                    n_waddr = p_rdata[AW-1:0];
                    n_wdata = n_rdata;
                end
                else
                begin
                    head_next = n_rdata;
                end
                if (is_node(n_rdata))
                begin
                    p_we = 1'b1;
                    p_waddr = n_rdata[AW-1:0];
                    p_wdata = p_rdata;
                end
                else
                begin
                    tail_next = p_rdata;
                end
                if (cur_reg == t_reg)
                begin
                    cur_next = NIL;
                end
                s_we = 1'b1;
                s_waddr = fc_reg[AW-1:0];
                s_wdata = t_reg[AW-1:0];
                fc_next = fc_reg + LW'(1);
                len_next = len_reg - LW'(1);
                state_next = S_DONE;
            end
            S_ALLOC:
            begin
                // Pop a node and fill its value and links
                n_next = new_node;
                fc_next = pop_pos;
                if (pop_pos < low_reg)
                begin
                    low_next = pop_pos;
                end
                len_next = len_reg + LW'(1);
                v_we = 1'b1;
                v_waddr = new_node[AW-1:0];
                v_wdata = VALUE_WIDTH'(val_reg);
                n_we = 1'b1;
                n_waddr = new_node[AW-1:0];
                p_we = 1'b1;
                p_waddr = new_node[AW-1:0];
                case (op_reg)
                    OP_INS_FIRST:
                    begin
                        nb_next = head_reg;
                        p_wdata = NIL;
                        n_wdata = head_reg;
                    end
                    OP_INS_LAST:
                    begin
                        nb_next = tail_reg;
                        p_wdata = tail_reg;
                        n_wdata = NIL;
                    end
                    OP_INS_AFTER:
                    begin
                        nb_next = n_rdata;
                        p_wdata = cur_reg;
                        n_wdata = n_rdata;
                    end
                    default:
                    begin
                        nb_next = p_rdata;
                        p_wdata = p_rdata;
                        n_wdata = cur_reg;
                    end
                endcase
                state_next = S_LINK;
            end
            S_LINK:
            begin
                // Point the neighbors at the new node
                case (op_reg)
                    OP_INS_FIRST:
                    begin
                        p_we = is_node(nb_reg);
                        p_waddr = nb_reg[AW-1:0];
                        p_wdata = n_reg;
                        if (!is_node(nb_reg))
                        begin
                            tail_next = n_reg;
                        end
                        head_next = n_reg;
                    end
                    OP_INS_LAST:
                    begin
                        n_we = is_node(nb_reg);
                        n_waddr = nb_reg[AW-1:0];
                        n_wdata = n_reg;
                        if (!is_node(nb_reg))
                        begin
                            head_next = n_reg;
                        end
                        tail_next = n_reg;
                    end
                    OP_INS_AFTER:
                    begin
                        n_we = 1'b1;
                        n_waddr = cur_reg[AW-1:0];
                        n_wdata = n_reg;
                        p_we = is_node(nb_reg);
                        p_waddr = nb_reg[AW-1:0];
                        p_wdata = n_reg;
                        if (!is_node(nb_reg))
                        begin
                            tail_next = n_reg;
                        end
                    end
                    default:
                    begin
                        p_we = 1'b1;
                        p_waddr = cur_reg[AW-1:0];
                        p_wdata = n_reg;
                        n_we = is_node(nb_reg);
                        n_waddr = nb_reg[AW-1:0];
                        n_wdata = n_reg;
                        if (!is_node(nb_reg))
                        begin
                            head_next = n_reg;
                        end
                    end
                endcase
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    o_value_next = rv_reg;
                    o_rvalid_next = rvalid_reg;
                    o_err_next = err_reg;
                    o_cur_next = is_node(cur_reg);
                    o_cnt_next = len_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg <= NIL;
            tail_reg <= NIL;
            cur_reg <= NIL;
            len_reg <= '0;
            fc_reg <= NIL;
            low_reg <= NIL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            cur_reg <= cur_next;
            len_reg <= len_next;
            fc_reg <= fc_next;
            low_reg <= low_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        val_reg <= val_next;
        t_reg <= t_next;
        n_reg <= n_next;
        nb_reg <= nb_next;
        rv_reg <= rv_next;
        rvalid_reg <= rvalid_next;
        err_reg <= err_next;
        o_value_reg <= o_value_next;
        o_rvalid_reg <= o_rvalid_next;
        o_err_reg <= o_err_next;
        o_cur_reg <= o_cur_next;
        o_cnt_reg <= o_cnt_next;
    end

    // Assertions
    `DLLCE_ASSERT_SAME(a_pool_sum, 1'b1, (fc_reg + len_reg) == NIL)
    `DLLCE_ASSERT_SAME(a_empty_head, state_reg == S_IDLE, (len_reg == '0) == (head_reg == NIL))
    `DLLCE_ASSERT_SAME(a_empty_tail, state_reg == S_IDLE, (len_reg == '0) == (tail_reg == NIL))
    `DLLCE_ASSERT_NEXT(a_deliver, state_reg == S_DONE && (!out_valid_reg || rsp.ready),
        state_reg == S_IDLE && out_valid_reg)
endmodule
`default_nettype wire
